@@ sv/ppa_pkg.sv @@
// shared widths and control/status types for the planar polygon area block
`default_nettype none

package ppa_pkg;

    localparam int COORD_W    = 24;
    localparam int NORM_W     = 18;
    localparam int AREA_W     = 56;
    localparam int SUM_W      = 64;
    localparam int PROD_W     = 2 * COORD_W;
    localparam int FRAC_SHIFT = 16;

    typedef struct packed {
        logic load;
        logic mul_a;
        logic mul_b;
        logic acc;
        logic close;
        logic div_start;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic err;
        logic div_busy;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

@@ sv/ppa_if.sv @@
// vertex and area channel interfaces
`default_nettype none

interface ppa_in_if;
    logic                                valid;
    logic                                ready;
    logic                                first_vertex;
    logic                                last_vertex;
    logic signed [ppa_pkg::COORD_W-1:0]  pos_x;
    logic signed [ppa_pkg::COORD_W-1:0]  pos_y;
    logic signed [ppa_pkg::COORD_W-1:0]  pos_z;
    logic signed [ppa_pkg::NORM_W-1:0]   normal_x;
    logic signed [ppa_pkg::NORM_W-1:0]   normal_y;
    logic signed [ppa_pkg::NORM_W-1:0]   normal_z;

    modport source (
        output valid, first_vertex, last_vertex, pos_x, pos_y, pos_z,
               normal_x, normal_y, normal_z,
        input  ready
    );
    modport sink (
        input  valid, first_vertex, last_vertex, pos_x, pos_y, pos_z,
               normal_x, normal_y, normal_z,
        output ready
    );
endinterface

interface ppa_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [ppa_pkg::AREA_W-1:0]   area;
    logic                                error;

    modport source (output valid, area, error, input ready);
    modport sink (input valid, area, error, output ready);
endinterface

`default_nettype wire

@@ sv/ppa_div.sv @@
// restoring divider, one quotient bit per cycle, with q32.24 saturation
`default_nettype none

module ppa_div (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    input  wire logic signed [ppa_pkg::SUM_W-1:0]    i_sum,
    input  wire logic signed [ppa_pkg::NORM_W-1:0]   i_norm,
    output logic                                     o_busy,
    output logic                                     o_done,
    output logic signed [ppa_pkg::AREA_W-1:0]        o_quot
);

    localparam int DVD_W = ppa_pkg::SUM_W + ppa_pkg::FRAC_SHIFT;
    localparam int DEN_W = ppa_pkg::NORM_W + 1;
    localparam int Q_W   = ppa_pkg::AREA_W - 1;
    localparam int CNT_W = $clog2(DVD_W + 1);
    localparam logic [ppa_pkg::AREA_W-1:0] Q_MAX = {1'b0, {(ppa_pkg::AREA_W-1){1'b1}}};
    localparam logic [ppa_pkg::AREA_W-1:0] Q_MIN = {1'b1, {(ppa_pkg::AREA_W-1){1'b0}}};

    logic                        r_busy;
    logic                        r_done;
    logic [CNT_W-1:0]            r_cnt;
    logic [DVD_W-1:0]            r_dvd;
    logic [DEN_W-1:0]            r_den;
    logic [DEN_W-1:0]            r_rem;
    logic [Q_W-1:0]              r_q;
    logic                        r_sticky;
    logic                        r_neg;

    logic [ppa_pkg::SUM_W-1:0]   w_mag;
    logic [ppa_pkg::NORM_W-1:0]  w_nabs;
    logic [DEN_W:0]              w_rsh;
    logic [DEN_W:0]              w_rdiff;
    logic                        w_ge;
    logic [ppa_pkg::AREA_W-1:0]  w_qext;

    assign w_mag   = i_sum[ppa_pkg::SUM_W-1] ? ppa_pkg::SUM_W'(-i_sum) : ppa_pkg::SUM_W'(i_sum);
    assign w_nabs  = i_norm[ppa_pkg::NORM_W-1] ? ppa_pkg::NORM_W'(-i_norm)
                                                : ppa_pkg::NORM_W'(i_norm);
    assign w_rsh   = {r_rem, r_dvd[DVD_W-1]};
    assign w_rdiff = w_rsh - {1'b0, r_den};
    assign w_ge    = w_rsh >= {1'b0, r_den};
    assign w_qext  = {1'b0, r_q};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd    <= {w_mag, {ppa_pkg::FRAC_SHIFT{1'b0}}};
            r_den    <= {w_nabs, 1'b0};
            r_rem    <= '0;
            r_q      <= '0;
            r_sticky <= 1'b0;
            r_neg    <= i_sum[ppa_pkg::SUM_W-1] ^ i_norm[ppa_pkg::NORM_W-1];
        end else if (r_busy) begin
            r_dvd    <= {r_dvd[DVD_W-2:0], 1'b0};
            r_rem    <= w_ge ? w_rdiff[DEN_W-1:0] : w_rsh[DEN_W-1:0];
            r_q      <= {r_q[Q_W-2:0], w_ge};
            r_sticky <= r_sticky | r_q[Q_W-1];
        end
    end

    always_comb begin
        if (r_sticky) begin
            o_quot = r_neg ? Q_MIN : Q_MAX;
        end else begin
            o_quot = r_neg ? ppa_pkg::AREA_W'(-w_qext) : w_qext;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;

endmodule

`default_nettype wire

@@ sv/ppa_dp.sv @@
// datapath: projection, shoelace accumulation, divider and result register
`default_nettype none

module ppa_dp (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire ppa_pkg::t_cmd i_cmd,
    output ppa_pkg::t_sts    o_sts,
    ppa_in_if.sink           i_vtx,
    ppa_out_if.source        o_res
);

    typedef enum logic [1:0] {
        AXIS_Z = 2'd0,
        AXIS_X = 2'd1,
        AXIS_Y = 2'd2
    } t_axis;

    localparam int SW = ppa_pkg::SUM_W;
    localparam logic [1:0] CNT_SAT = 2'd3;
    localparam logic signed [SW-1:0] SUM_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SUM_MIN = {1'b1, {(SW-1){1'b0}}};

    t_axis                                r_axis;
    logic signed [ppa_pkg::NORM_W-1:0]    r_div;
    logic signed [ppa_pkg::COORD_W-1:0]   r_first_u, r_first_v;
    logic signed [ppa_pkg::COORD_W-1:0]   r_prev_u, r_prev_v;
    logic signed [ppa_pkg::COORD_W-1:0]   r_cur_u, r_cur_v;
    logic signed [ppa_pkg::PROD_W-1:0]    r_prod_a, r_prod_b;
    logic signed [SW-1:0]                 r_sum;
    logic [1:0]                           r_count;
    logic                                 r_skip;
    logic                                 r_last;
    logic                                 r_out_valid;
    logic signed [ppa_pkg::AREA_W-1:0]    r_area;
    logic                                 r_error;

    logic                                 w_new;
    logic [ppa_pkg::NORM_W-1:0]           w_ax, w_ay, w_az;
    t_axis                                w_axis_sel, w_axis;
    logic signed [ppa_pkg::NORM_W-1:0]    w_div_sel;
    logic signed [ppa_pkg::COORD_W-1:0]   w_u, w_v;
    logic [1:0]                           w_cnt_base;
    logic signed [ppa_pkg::COORD_W-1:0]   w_ma_l, w_ma_r, w_mb_l, w_mb_r;
    logic signed [ppa_pkg::PROD_W-1:0]    w_ma, w_mb;
    logic signed [SW:0]                   w_diff, w_tot;
    logic signed [SW-1:0]                 w_sum_sat;
    logic                                 w_err;
    logic                                 w_div_busy, w_div_done;
    logic signed [ppa_pkg::AREA_W-1:0]    w_quot;

    assign w_new = i_vtx.first_vertex || (r_count == 2'd0);
    assign w_ax  = i_vtx.normal_x[ppa_pkg::NORM_W-1] ? ppa_pkg::NORM_W'(-i_vtx.normal_x)
                                                      : ppa_pkg::NORM_W'(i_vtx.normal_x);
    assign w_ay  = i_vtx.normal_y[ppa_pkg::NORM_W-1] ? ppa_pkg::NORM_W'(-i_vtx.normal_y)
                                                      : ppa_pkg::NORM_W'(i_vtx.normal_y);
    assign w_az  = i_vtx.normal_z[ppa_pkg::NORM_W-1] ? ppa_pkg::NORM_W'(-i_vtx.normal_z)
                                                      : ppa_pkg::NORM_W'(i_vtx.normal_z);

    // largest normal component picks the dropped axis
    always_comb begin
        w_axis_sel = AXIS_Z;
        w_div_sel  = i_vtx.normal_z;
        if (w_ax > w_ay) begin
            if (w_ax > w_az) begin
                w_axis_sel = AXIS_X;
                w_div_sel  = i_vtx.normal_x;
            end
        end else if (w_ay > w_az) begin
            w_axis_sel = AXIS_Y;
            w_div_sel  = i_vtx.normal_y;
        end
    end

    assign w_axis = w_new ? w_axis_sel : r_axis;

    always_comb begin
        case (w_axis)
            AXIS_X: begin
                w_u = i_vtx.pos_y;
                w_v = i_vtx.pos_z;
            end
            AXIS_Y: begin
                w_u = i_vtx.pos_z;
                w_v = i_vtx.pos_x;
            end
            default: begin
                w_u = i_vtx.pos_x;
                w_v = i_vtx.pos_y;
            end
        endcase
    end

    assign w_cnt_base = w_new ? 2'd0 : r_count;

    // edge operands, closing edge runs from latest back to first vertex
    assign w_ma_l = r_prev_u;
    assign w_ma_r = i_cmd.close ? r_first_v : r_cur_v;
    assign w_mb_l = i_cmd.close ? r_first_u : r_cur_u;
    assign w_mb_r = r_prev_v;
    assign w_ma   = w_ma_l * w_ma_r;
    assign w_mb   = w_mb_l * w_mb_r;

    assign w_diff = (SW+1)'(r_prod_a) - (SW+1)'(r_prod_b);
    assign w_tot  = (SW+1)'(r_sum) + w_diff;
    always_comb begin
        if (w_tot[SW] != w_tot[SW-1]) begin
            w_sum_sat = w_tot[SW] ? SUM_MIN : SUM_MAX;
        end else begin
            w_sum_sat = w_tot[SW-1:0];
        end
    end

    assign w_err = (r_count != CNT_SAT) || (r_div == '0);

    ppa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_sum   (r_sum),
        .i_norm  (r_div),
        .o_busy  (w_div_busy),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis      <= AXIS_Z;
            r_count     <= 2'd0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_count <= (w_cnt_base == CNT_SAT) ? CNT_SAT : w_cnt_base + 2'd1;
                if (w_new) begin
                    r_axis <= w_axis_sel;
                    r_sum  <= '0;
                end
            end else if (i_cmd.acc && (i_cmd.close || !r_skip)) begin
                r_sum <= w_sum_sat;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
                r_count     <= 2'd0;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cur_u <= w_u;
            r_cur_v <= w_v;
            r_last  <= i_vtx.last_vertex;
            r_skip  <= w_new;
            if (w_new) begin
                r_div     <= w_div_sel;
                r_first_u <= w_u;
                r_first_v <= w_v;
            end
        end
        if (i_cmd.mul_a) begin
            r_prod_a <= w_ma;
        end
        if (i_cmd.mul_b) begin
            r_prod_b <= w_mb;
        end
        if (i_cmd.acc && !i_cmd.close) begin
            r_prev_u <= r_cur_u;
            r_prev_v <= r_cur_v;
        end
        if (i_cmd.out_load) begin
            r_area  <= w_err ? '0 : w_quot;
            r_error <= w_err;
        end
    end

    assign o_sts.last     = r_last;
    assign o_sts.err      = w_err;
    assign o_sts.div_busy = w_div_busy;
    assign o_sts.div_done = w_div_done;
    assign o_sts.out_free = !r_out_valid || o_res.ready;

    assign o_res.valid = r_out_valid;
    assign o_res.area  = r_area;
    assign o_res.error = r_error;

endmodule

`default_nettype wire

@@ sv/ppa_ctrl.sv @@
// controller state machine sequencing vertex, closing edge and division
`default_nettype none

module ppa_ctrl (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire ppa_pkg::t_sts i_sts,
    output ppa_pkg::t_cmd   o_cmd
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_MUL_A  = 10'b00_0000_0010,
        S_MUL_B  = 10'b00_0000_0100,
        S_ACC    = 10'b00_0000_1000,
        S_CL_A   = 10'b00_0001_0000,
        S_CL_B   = 10'b00_0010_0000,
        S_CL_ACC = 10'b00_0100_0000,
        S_DIV_GO = 10'b00_1000_0000,
        S_DIV    = 10'b01_0000_0000,
        S_RESULT = 10'b10_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL_A;
                end
            end
            S_MUL_A: begin
                o_cmd.mul_a = 1'b1;
                n_state     = S_MUL_B;
            end
            S_MUL_B: begin
                o_cmd.mul_b = 1'b1;
                n_state     = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = i_sts.last ? S_CL_A : S_IDLE;
            end
            S_CL_A: begin
                o_cmd.close = 1'b1;
                o_cmd.mul_a = 1'b1;
                n_state     = S_CL_B;
            end
            S_CL_B: begin
                o_cmd.close = 1'b1;
                o_cmd.mul_b = 1'b1;
                n_state     = S_CL_ACC;
            end
            S_CL_ACC: begin
                o_cmd.close = 1'b1;
                o_cmd.acc   = 1'b1;
                n_state     = i_sts.err ? S_RESULT : S_DIV_GO;
            end
            S_DIV_GO: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    a_div_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |-> !i_sts.err)
        else $error("division started on an error polygon");

    a_load_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> !i_sts.div_busy)
        else $error("vertex beat taken while divider busy");

    a_done_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && i_sts.div_done) |=> r_state == S_RESULT)
        else $error("divider finish not followed by result");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.div_done |-> r_state == S_DIV)
        else $error("divider finished outside division wait");

endmodule

`default_nettype wire

@@ sv/planar_polygon_area_3d_top.sv @@
// top level of the planar polygon area block
//
//   port    | dir | beat contents
//   --------+-----+-----------------------------------------------------
//   i_vtx   | in  | first/last flags, vertex q12.12, normal q2.16
//   o_res   | out | area q32.24 saturated, error flag
//
// a vertex beat runs accept, two 24x24 products, then accumulate;
// a last vertex then adds the closing edge (two products, accumulate), then the
// one-bit-per-cycle restoring divider (80 quotient bits), then a load of
// the result; an error result skips the divider
// the result register lets the next vertex in while a result waits
// reset is synchronous, active low, and clears control state and the running sum
`default_nettype none

module planar_polygon_area_3d_top (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    ppa_in_if.sink      i_vtx,
    ppa_out_if.source   o_res
);

    ppa_pkg::t_cmd w_cmd;
    ppa_pkg::t_sts w_sts;
    logic          w_in_ready;

    ppa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_vtx.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    ppa_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .i_vtx   (i_vtx),
        .o_res   (o_res)
    );

    assign i_vtx.ready = w_in_ready;

endmodule

`default_nettype wire
